>>> rtl/lpd_pkg.sv
// shared constants and types for the length-prefixed packet deframer
`default_nettype none
package lpd_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LEN_W = 32;
	localparam int unsigned PREFIX_BYTES = 4;
	localparam logic [LEN_W-1:0] MAX_LEN_RESET = 32'd4096;

	// beat held in the input register
	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] rx_byte;
	} lpd_beat_t;

endpackage
`default_nettype wire

>>> rtl/lpd_rx_if.sv
// receive byte channel
`default_nettype none
interface lpd_rx_if;
	logic                       valid;
	logic                       ready;
	logic [lpd_pkg::BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

>>> rtl/lpd_pkt_if.sv
// deframed payload channel
`default_nettype none
interface lpd_pkt_if;
	logic                       valid;
	logic                       ready;
	logic [lpd_pkg::BYTE_W-1:0] payload_byte;
	logic                       last_of_packet;
	logic                       empty_packet;

	modport source (output valid, output payload_byte, output last_of_packet,
		output empty_packet, input ready);
	modport sink (input valid, input payload_byte, input last_of_packet,
		input empty_packet, output ready);
endinterface
`default_nettype wire

>>> rtl/lpd_cfg_if.sv
// configuration write channel for the maximum packet length
`default_nettype none
interface lpd_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [lpd_pkg::LEN_W-1:0] max_packet_length;

	modport source (output valid, output max_packet_length, input ready);
	modport sink (input valid, input max_packet_length, output ready);
endinterface
`default_nettype wire

>>> rtl/lpd_in_stage.sv
// input register for received bytes
`default_nettype none
module lpd_in_stage (
	input  wire logic       clk,
	input  wire logic       arst_n,
	lpd_rx_if.sink          rx,
	input  wire logic       advance,
	output lpd_pkg::lpd_beat_t beat_s1
);

	logic                       valid_s1;
	logic [lpd_pkg::BYTE_W-1:0] byte_s1;

	// take a new beat when the register is empty or drains this cycle
	assign rx.ready = !valid_s1 || advance;
	assign beat_s1 = '{valid: valid_s1, rx_byte: byte_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

endmodule
`default_nettype wire

>>> rtl/lpd_core.sv
// framing state, length check and result register
`default_nettype none
module lpd_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire lpd_pkg::lpd_beat_t beat_s1,
	output logic               advance,
	lpd_pkt_if.source          pkt,
	lpd_cfg_if.sink            cfg
);

	typedef enum logic [1:0] {
		PH_LENGTH = 2'd0,
		PH_PASS   = 2'd1,
		PH_DROP   = 2'd2
	} phase_t;

	phase_t                     phase_q, phase_d;
	logic [lpd_pkg::LEN_W-1:0]  packet_length_q, packet_length_d;
	logic [lpd_pkg::LEN_W-1:0]  byte_count_q, byte_count_d;
	logic [lpd_pkg::LEN_W-1:0]  max_len_q;
	logic [lpd_pkg::LEN_W-1:0]  cnt_inc;
	logic [lpd_pkg::LEN_W-1:0]  len_shift;
	logic                       fire;
	logic                       emit;
	logic [lpd_pkg::BYTE_W-1:0] res_byte;
	logic                       res_last;
	logic                       res_empty;
	logic                       out_valid_q;
	logic [lpd_pkg::BYTE_W-1:0] out_byte_q;
	logic                       out_last_q;
	logic                       out_empty_q;

	assign advance = !out_valid_q || pkt.ready;
	assign fire = beat_s1.valid && advance;
	assign cfg.ready = 1'b1;

	assign pkt.valid = out_valid_q;
	assign pkt.payload_byte = out_byte_q;
	assign pkt.last_of_packet = out_last_q;
	assign pkt.empty_packet = out_empty_q;

	assign cnt_inc = byte_count_q + 1'b1;
	assign len_shift = {packet_length_q[lpd_pkg::LEN_W-lpd_pkg::BYTE_W-1:0], beat_s1.rx_byte};

	always_comb begin
		phase_d = phase_q;
		packet_length_d = packet_length_q;
		byte_count_d = cnt_inc;
		emit = 1'b0;
		res_byte = beat_s1.rx_byte;
		res_last = 1'b0;
		res_empty = 1'b0;
		case (phase_q)
			PH_PASS: begin
				emit = 1'b1;
				if (cnt_inc == packet_length_q) begin
					byte_count_d = '0;
					phase_d = PH_LENGTH;
					res_last = 1'b1;
				end
			end
			PH_DROP: begin
				if (cnt_inc == packet_length_q) begin
					byte_count_d = '0;
					phase_d = PH_LENGTH;
				end
			end
			default: begin
				// length bytes arrive msb first
				phase_d = PH_LENGTH;
				packet_length_d = len_shift;
				if (cnt_inc == lpd_pkg::LEN_W'(lpd_pkg::PREFIX_BYTES)) begin
					byte_count_d = '0;
					if (len_shift == '0) begin
						emit = 1'b1;
						res_byte = '0;
						res_last = 1'b1;
						res_empty = 1'b1;
					end else if (len_shift <= max_len_q) begin
						phase_d = PH_PASS;
					end else begin
						phase_d = PH_DROP;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LENGTH;
			packet_length_q <= '0;
			byte_count_q <= '0;
			max_len_q <= lpd_pkg::MAX_LEN_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				max_len_q <= cfg.max_packet_length;
			end
			if (fire) begin
				phase_q <= phase_d;
				packet_length_q <= packet_length_d;
				byte_count_q <= byte_count_d;
			end
			if (advance) begin
				out_valid_q <= fire && emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			out_byte_q <= res_byte;
			out_last_q <= res_last;
			out_empty_q <= res_empty;
		end
	end

	// an empty-packet result always closes the packet with a zero byte
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_empty_q |-> out_last_q && (out_byte_q == '0))
		else $error("empty packet result without last mark or with data");

	// length counting never runs past the prefix
	a_prefix_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_LENGTH |-> byte_count_q < lpd_pkg::LEN_W'(lpd_pkg::PREFIX_BYTES))
		else $error("length byte count beyond prefix");

	// every beat taken while passing a packet shows up as a result
	a_pass_emits: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (phase_q == PH_PASS) |=> out_valid_q)
		else $error("payload beat lost");

	// dropped beats produce nothing
	a_drop_silent: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (phase_q == PH_DROP) |=> !out_valid_q)
		else $error("result produced while dropping");

endmodule
`default_nettype wire

>>> rtl/length_prefixed_packet_deframer_unit.sv
// top level of the length-prefixed packet deframer
//
//  channel | dir | payload                                       | accepted when
//  rx      | in  | rx_byte[7:0]                                  | rx.valid & rx.ready
//  pkt     | out | payload_byte[7:0], last_of_packet, empty_packet | pkt.valid & pkt.ready
//  cfg     | in  | max_packet_length[31:0]                       | cfg.valid & cfg.ready
//
// one byte per cycle unless pkt stalls; bytes pass the input then the result register
// cycle time is set by the 32-bit count increment and compare against the length
// arst_n clears state to reading a length, max_packet_length back to 4096
// a stall on pkt holds the result register; one more byte waits in the input register
// cfg.ready is always high
`default_nettype none
module length_prefixed_packet_deframer_unit (
	input wire logic clk,
	input wire logic arst_n,
	lpd_rx_if.sink   rx,
	lpd_pkt_if.source pkt,
	lpd_cfg_if.sink  cfg
);

	lpd_pkg::lpd_beat_t beat_s1;
	logic               advance;

	lpd_in_stage u_in_stage (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx),
		.advance (advance),
		.beat_s1 (beat_s1)
	);

	lpd_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.beat_s1 (beat_s1),
		.advance (advance),
		.pkt     (pkt),
		.cfg     (cfg)
	);

endmodule
`default_nettype wire
